// ===== sv/rrtp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// rrtp_pkg: shared types and codes for the round-robin task picker.
// No dependencies; used by rrtp_ctrl and round_robin_task_picker_unit.

package rrtp_pkg;

    // Fixed field widths of the transaction payloads
    localparam int REQ_W   = 2;
    localparam int TASK_W  = 4;
    localparam int STATE_W = 3;
    localparam int TICKS_W = 16;

    // Time quantum after reset
    localparam logic [TICKS_W-1:0] QUANTUM_RESET = 16'd10;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_YIELD       = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE_STATE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE_TICKS = 2'd2;

    // Task state codes
    localparam logic [STATE_W-1:0] ST_FREE     = 3'd0;
    localparam logic [STATE_W-1:0] ST_RUNNABLE = 3'd1;
    localparam logic [STATE_W-1:0] ST_RUNNING  = 3'd2;
    localparam logic [STATE_W-1:0] ST_SLEEP    = 3'd3;
    localparam logic [STATE_W-1:0] ST_STOP     = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [TASK_W-1:0]  task_index;
        logic [STATE_W-1:0] new_state;
        logic [TICKS_W-1:0] ticks_value;
    } task_req_t;

    typedef struct packed {
        logic [TASK_W-1:0]  current_task;
        logic               switched;
        logic [TICKS_W-1:0] current_ticks;
    } task_rsp_t;

endpackage

`default_nettype wire

// ===== sv/rrtp_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// rrtp_mem: simple dual-port synchronous RAM, one write and one read port,
// registered read data. No dependencies.

module rrtp_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/rrtp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// rrtp_ctrl: request sequencer and yield scanner of the task picker.
// Depends on rrtp_pkg; drives the state-table and ticks-table RAM ports.

module rrtp_ctrl #(
    parameter int NUM_TASKS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // request side
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire rrtp_pkg::task_req_t               s_req,
    input  wire logic [rrtp_pkg::TICKS_W-1:0]      quantum,
    // result side
    input  wire logic                              slot_free,
    output logic                                   rsp_load,
    output rrtp_pkg::task_rsp_t                    rsp,
    // state table RAM
    output logic                                   st_we,
    output logic [$clog2(NUM_TASKS)-1:0]           st_waddr,
    output logic [rrtp_pkg::STATE_W-1:0]           st_wdata,
    output logic                                   st_re,
    output logic [$clog2(NUM_TASKS)-1:0]           st_raddr,
    input  wire logic [rrtp_pkg::STATE_W-1:0]      st_rdata,
    // ticks table RAM
    output logic                                   tk_we,
    output logic [$clog2(NUM_TASKS)-1:0]           tk_waddr,
    output logic [rrtp_pkg::TICKS_W-1:0]           tk_wdata,
    output logic                                   tk_re,
    output logic [$clog2(NUM_TASKS)-1:0]           tk_raddr,
    input  wire logic [rrtp_pkg::TICKS_W-1:0]      tk_rdata
);

    localparam int IDX_W = $clog2(NUM_TASKS);
    localparam int CNT_W = $clog2(NUM_TASKS + 1);
    localparam int TW    = rrtp_pkg::TASK_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);
    localparam logic [CNT_W-1:0] N_CNT    = CNT_W'(NUM_TASKS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_YCUR,
        S_SCAN,
        S_DEMOTE,
        S_RDTK,
        S_RESP
    } fsm_t;

    fsm_t                        state_reg, state_next;
    logic [IDX_W-1:0]            cur_reg, cur_next;
    logic [IDX_W-1:0]            start_cur_reg, start_cur_next;
    logic [IDX_W-1:0]            old_cur_reg, old_cur_next;
    logic [IDX_W-1:0]            pos_reg, pos_next;
    logic [IDX_W-1:0]            eval_pos_reg, eval_pos_next;
    logic [CNT_W-1:0]            issue_cnt_reg, issue_cnt_next;
    logic [rrtp_pkg::STATE_W-1:0] cs_reg, cs_next;

    logic accept;
    logic idx_ok;
    logic cs_idle;

    // Round-robin successor of an index
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        r = (i == LAST_IDX) ? '0 : i + 1'b1;
        return r;
    endfunction

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign idx_ok  = (32'(s_req.task_index) < NUM_TASKS);
    // current task is free, asleep or stopped: a runnable entry may take over
    assign cs_idle = (cs_reg == rrtp_pkg::ST_FREE) || (cs_reg == rrtp_pkg::ST_SLEEP) ||
                     (cs_reg == rrtp_pkg::ST_STOP);

    // Result payload
    assign rsp.current_task  = TW'(cur_reg);
    assign rsp.switched      = (cur_reg != start_cur_reg);
    assign rsp.current_ticks = tk_rdata;

    // Next-state and RAM port logic
    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        start_cur_next = start_cur_reg;
        old_cur_next   = old_cur_reg;
        pos_next       = pos_reg;
        eval_pos_next  = eval_pos_reg;
        issue_cnt_next = issue_cnt_reg;
        cs_next        = cs_reg;
        rsp_load       = 1'b0;
        st_we          = 1'b0;
        st_waddr       = pos_reg;
        st_wdata       = rrtp_pkg::ST_FREE;
        st_re          = 1'b0;
        st_raddr       = pos_reg;
        tk_we          = 1'b0;
        tk_waddr       = pos_reg;
        tk_wdata       = '0;
        tk_re          = 1'b0;
        tk_raddr       = cur_reg;

        unique case (state_reg)
            // sweep both tables to their reset values
            S_CLEAR: begin
                st_we = 1'b1;
                tk_we = 1'b1;
                if (pos_reg == LAST_IDX) begin
                    pos_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    pos_next = next_idx(pos_reg);
                end
            end

            S_IDLE: begin
                if (accept) begin
                    start_cur_next = cur_reg;
                    priority case (s_req.req_type)
                        rrtp_pkg::REQ_YIELD: begin
                            st_re      = 1'b1;
                            st_raddr   = cur_reg;
                            pos_next   = next_idx(cur_reg);
                            state_next = S_YCUR;
                        end
                        rrtp_pkg::REQ_WRITE_STATE: begin
                            st_we      = idx_ok;
                            st_waddr   = IDX_W'(s_req.task_index);
                            st_wdata   = s_req.new_state;
                            state_next = S_RDTK;
                        end
                        rrtp_pkg::REQ_WRITE_TICKS: begin
                            tk_we      = idx_ok;
                            tk_waddr   = IDX_W'(s_req.task_index);
                            tk_wdata   = s_req.ticks_value;
                            state_next = S_RDTK;
                        end
                        default: begin
                            state_next = S_RDTK;
                        end
                    endcase
                end
            end

            // capture current task state, issue first scan read
            S_YCUR: begin
                cs_next        = st_rdata;
                st_re          = 1'b1;
                st_raddr       = pos_reg;
                eval_pos_next  = pos_reg;
                pos_next       = next_idx(pos_reg);
                issue_cnt_next = CNT_W'(1);
                state_next     = S_SCAN;
            end

            // one read issued and one entry evaluated per cycle
            S_SCAN: begin
                if (issue_cnt_reg < N_CNT) begin
                    st_re          = 1'b1;
                    st_raddr       = pos_reg;
                    eval_pos_next  = pos_reg;
                    pos_next       = next_idx(pos_reg);
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                if (st_rdata == rrtp_pkg::ST_RUNNABLE && cs_reg == rrtp_pkg::ST_RUNNING) begin
                    // take over; old current is demoted next cycle
                    st_we        = 1'b1;
                    st_waddr     = eval_pos_reg;
                    st_wdata     = rrtp_pkg::ST_RUNNING;
                    tk_we        = 1'b1;
                    tk_waddr     = cur_reg;
                    tk_wdata     = quantum;
                    old_cur_next = cur_reg;
                    cur_next     = eval_pos_reg;
                    state_next   = S_DEMOTE;
                end else if (st_rdata == rrtp_pkg::ST_RUNNABLE && cs_idle) begin
                    st_we      = 1'b1;
                    st_waddr   = eval_pos_reg;
                    st_wdata   = rrtp_pkg::ST_RUNNING;
                    cur_next   = eval_pos_reg;
                    state_next = S_RDTK;
                end else begin
                    if (st_rdata == rrtp_pkg::ST_RUNNING) begin
                        // running entry becomes current, quantum reloaded
                        cur_next = eval_pos_reg;
                        cs_next  = rrtp_pkg::ST_RUNNING;
                        tk_we    = 1'b1;
                        tk_waddr = eval_pos_reg;
                        tk_wdata = quantum;
                    end
                    if (issue_cnt_reg == N_CNT) begin
                        state_next = S_RDTK;
                    end
                end
            end

            S_DEMOTE: begin
                st_we      = 1'b1;
                st_waddr   = old_cur_reg;
                st_wdata   = rrtp_pkg::ST_RUNNABLE;
                state_next = S_RDTK;
            end

            S_RDTK: begin
                tk_re      = 1'b1;
                state_next = S_RESP;
            end

            S_RESP: begin
                if (slot_free) begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registers
    always_ff @(posedge aclk) begin
        start_cur_reg <= start_cur_next;
        old_cur_reg   <= old_cur_next;
        eval_pos_reg  <= eval_pos_next;
        issue_cnt_reg <= issue_cnt_next;
        cs_reg        <= cs_next;
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            cur_reg   <= '0;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/round_robin_task_picker_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// round_robin_task_picker_unit: top level of the round-robin task picker.
// Depends on rrtp_pkg, rrtp_mem and rrtp_ctrl.

// Round-robin task picker. Task states and remaining tick counts live in two
// single-port-read RAMs of NUM_TASKS entries. Each request transaction yields
// exactly one result transaction, and one request is handled at a time.
// A state or ticks write reads back the current task's ticks, then waits in
// the response state until the output register is free. A yield reads the
// current task's state, then streams the state RAM one entry per cycle, with
// a demotion step when a running task is demoted; the scan ends early at the
// first runnable entry that takes over. After reset the block runs a clearing
// pass over every entry of both RAMs before it accepts its first request;
// quantum writes on cfg_wr_en are taken at any time.

module round_robin_task_picker_unit #(
    parameter int NUM_TASKS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic [rrtp_pkg::TICKS_W-1:0]  cfg_wr_data,
    // requests
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire rrtp_pkg::task_req_t           s_req,
    // results
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output rrtp_pkg::task_rsp_t                m_rsp
);

    localparam int IDX_W = $clog2(NUM_TASKS);

    logic [rrtp_pkg::TICKS_W-1:0] quantum_reg;
    logic                         m_valid_reg;
    rrtp_pkg::task_rsp_t          m_rsp_reg;

    logic                         rsp_load;
    rrtp_pkg::task_rsp_t          rsp;

    logic                         st_we, st_re;
    logic [IDX_W-1:0]             st_waddr, st_raddr;
    logic [rrtp_pkg::STATE_W-1:0] st_wdata, st_rdata;
    logic                         tk_we, tk_re;
    logic [IDX_W-1:0]             tk_waddr, tk_raddr;
    logic [rrtp_pkg::TICKS_W-1:0] tk_wdata, tk_rdata;

    // Time quantum register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg <= rrtp_pkg::QUANTUM_RESET;
        end else if (cfg_wr_en) begin
            quantum_reg <= cfg_wr_data;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (rsp_load) begin
            m_rsp_reg <= rsp;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rsp_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    rrtp_ctrl #(
        .NUM_TASKS (NUM_TASKS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .quantum   (quantum_reg),
        .slot_free (!m_valid_reg || m_ready),
        .rsp_load  (rsp_load),
        .rsp       (rsp),
        .st_we     (st_we),
        .st_waddr  (st_waddr),
        .st_wdata  (st_wdata),
        .st_re     (st_re),
        .st_raddr  (st_raddr),
        .st_rdata  (st_rdata),
        .tk_we     (tk_we),
        .tk_waddr  (tk_waddr),
        .tk_wdata  (tk_wdata),
        .tk_re     (tk_re),
        .tk_raddr  (tk_raddr),
        .tk_rdata  (tk_rdata)
    );

    // Task state table
    rrtp_mem #(
        .DEPTH (NUM_TASKS),
        .WIDTH (rrtp_pkg::STATE_W)
    ) u_state_mem (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // Remaining ticks table
    rrtp_mem #(
        .DEPTH (NUM_TASKS),
        .WIDTH (rrtp_pkg::TICKS_W)
    ) u_ticks_mem (
        .aclk  (aclk),
        .we    (tk_we),
        .waddr (tk_waddr),
        .wdata (tk_wdata),
        .re    (tk_re),
        .raddr (tk_raddr),
        .rdata (tk_rdata)
    );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for round_robin_task_picker_unit.
// Depends on rrtp_pkg and the picker RTL. Predicts every result transaction
// in-bench and compares it field by field with the block's output.

module testbench;

    localparam int NUM_TASKS   = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 40;

    // Request code the block does not define; it must change nothing
    localparam logic [rrtp_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic                          aclk;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [rrtp_pkg::TICKS_W-1:0]  cfg_wr_data = '0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    rrtp_pkg::task_req_t           s_req       = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    rrtp_pkg::task_rsp_t           m_rsp;

    // Shadow of the picker state, updated at each accepted request
    logic [rrtp_pkg::STATE_W-1:0]  sched_state [NUM_TASKS];
    logic [rrtp_pkg::TICKS_W-1:0]  sched_ticks [NUM_TASKS];
    int                            sched_cur;
    logic [rrtp_pkg::TICKS_W-1:0]  sched_quantum;

    rrtp_pkg::task_rsp_t           expected_rsp [$];
    int                            mismatch_count = 0;
    int unsigned                   cycle_count    = 0;
    bit                            tx_no_gaps     = 1'b0;
    logic                          hold_request   = 1'b0;

    round_robin_task_picker_unit #(
        .NUM_TASKS (NUM_TASKS)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req       (s_req),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rsp       (m_rsp)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Applies one request to the shadow state and returns the result it gives
    function automatic rrtp_pkg::task_rsp_t apply_request(input rrtp_pkg::task_req_t r);
        rrtp_pkg::task_rsp_t          rsp;
        int                           pos;
        int                           prior;
        int                           n;
        logic [rrtp_pkg::STATE_W-1:0] cs;
        bit                           done;
        prior = sched_cur;
        case (r.req_type)
            rrtp_pkg::REQ_YIELD: begin
                // round-robin scan, starting after the current task and
                // ending on the current task itself
                pos  = (sched_cur + 1) % NUM_TASKS;
                done = 1'b0;
                for (n = 0; n < NUM_TASKS && !done; n++) begin
                    if (sched_state[pos] == rrtp_pkg::ST_RUNNABLE) begin
                        cs = sched_state[sched_cur];
                        if (cs == rrtp_pkg::ST_RUNNING) begin
                            // demote the running task and refill its quantum
                            sched_state[sched_cur] = rrtp_pkg::ST_RUNNABLE;
                            sched_ticks[sched_cur] = sched_quantum;
                        end
                        // undefined codes and runnable hold on to the CPU
                        if (cs == rrtp_pkg::ST_RUNNING || cs == rrtp_pkg::ST_FREE ||
                            cs == rrtp_pkg::ST_SLEEP || cs == rrtp_pkg::ST_STOP) begin
                            sched_cur        = pos;
                            sched_state[pos] = rrtp_pkg::ST_RUNNING;
                            done             = 1'b1;
                        end
                    end else if (sched_state[pos] == rrtp_pkg::ST_RUNNING) begin
                        // running entry picked up on the way, scan goes on
                        sched_cur        = pos;
                        sched_ticks[pos] = sched_quantum;
                    end
                    pos = (pos + 1) % NUM_TASKS;
                end
            end
            rrtp_pkg::REQ_WRITE_STATE: begin
                if (r.task_index < NUM_TASKS)
                    sched_state[r.task_index] = r.new_state;
            end
            rrtp_pkg::REQ_WRITE_TICKS: begin
                if (r.task_index < NUM_TASKS)
                    sched_ticks[r.task_index] = r.ticks_value;
            end
            default: ;
        endcase
        rsp.current_task  = sched_cur[rrtp_pkg::TASK_W-1:0];
        rsp.switched      = (sched_cur != prior);
        rsp.current_ticks = sched_ticks[sched_cur];
        return rsp;
    endfunction

    function automatic rrtp_pkg::task_req_t make_req(input logic [rrtp_pkg::REQ_W-1:0] kind,
                                                     input int idx,
                                                     input logic [rrtp_pkg::STATE_W-1:0] st,
                                                     input logic [rrtp_pkg::TICKS_W-1:0] ticks);
        rrtp_pkg::task_req_t r;
        r.req_type    = kind;
        r.task_index  = idx[rrtp_pkg::TASK_W-1:0];
        r.new_state   = st;
        r.ticks_value = ticks;
        return r;
    endfunction

    // Random request: mostly state writes and yields so tasks actually rotate
    function automatic rrtp_pkg::task_req_t random_request();
        rrtp_pkg::task_req_t r;
        int                  sel;
        int                  val;
        sel = $urandom_range(0, 99);
        if (sel < 30)      r.req_type = rrtp_pkg::REQ_YIELD;
        else if (sel < 72) r.req_type = rrtp_pkg::REQ_WRITE_STATE;
        else if (sel < 94) r.req_type = rrtp_pkg::REQ_WRITE_TICKS;
        else               r.req_type = REQ_UNUSED;
        val = $urandom_range(0, NUM_TASKS - 1);
        r.task_index = val[rrtp_pkg::TASK_W-1:0];
        sel = $urandom_range(0, 99);
        if (sel < 35)      r.new_state = rrtp_pkg::ST_RUNNABLE;
        else if (sel < 50) r.new_state = rrtp_pkg::ST_RUNNING;
        else if (sel < 62) r.new_state = rrtp_pkg::ST_SLEEP;
        else if (sel < 74) r.new_state = rrtp_pkg::ST_STOP;
        else if (sel < 88) r.new_state = rrtp_pkg::ST_FREE;
        else begin
            val = $urandom_range(5, 7);
            r.new_state = val[rrtp_pkg::STATE_W-1:0];
        end
        sel = $urandom_range(0, 99);
        if (sel < 8)       r.ticks_value = '0;
        else if (sel < 16) r.ticks_value = '1;
        else begin
            val = $urandom_range(0, 65535);
            r.ticks_value = val[rrtp_pkg::TICKS_W-1:0];
        end
        return r;
    endfunction

    // Sender idle time: mostly short, now and then long
    function automatic int pick_gap();
        int sel;
        if (tx_no_gaps)
            return 0;
        sel = $urandom_range(0, 99);
        if (sel < 45) return 0;
        if (sel < 80) return $urandom_range(1, 3);
        if (sel < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one request transaction and records its result once accepted.
    // Valid stays high across back-to-back transactions.
    task automatic send_request(input rrtp_pkg::task_req_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        expected_rsp.push_back(apply_request(r));
    endtask

    // Drop valid and let every outstanding result come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_rsp.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_quantum(input logic [rrtp_pkg::TICKS_W-1:0] value);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= value;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        sched_quantum  = value;
    endtask

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // Result checker: every result transaction against the oldest prediction
    always @(posedge aclk) begin : result_check
        rrtp_pkg::task_rsp_t want;
        if (m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_rsp.size() == 0) begin
                log_mismatch($sformatf("result with none pending: task %0d ticks %0d",
                                       m_rsp.current_task, m_rsp.current_ticks));
            end else begin
                want = expected_rsp.pop_front();
                if (m_rsp.current_task !== want.current_task)
                    log_mismatch($sformatf("current_task expected %0d got %0d",
                                           want.current_task, m_rsp.current_task));
                if (m_rsp.switched !== want.switched)
                    log_mismatch($sformatf("switched expected %0d got %0d",
                                           want.switched, m_rsp.switched));
                if (m_rsp.current_ticks !== want.current_ticks)
                    log_mismatch($sformatf("current_ticks expected %0d got %0d",
                                           want.current_ticks, m_rsp.current_ticks));
            end
        end
    end

    // Result-side ready: random stalls, quiet stretches, and a long hold on request
    initial begin : result_ready_gen
        int sel;
        int len;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request <= 1'b0;
                m_ready      <= 1'b0;
                len           = HOLD_CYCLES;
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 10) begin
                    m_ready <= 1'b1;
                    len      = $urandom_range(50, 150);
                end else if (sel < 55) begin
                    m_ready <= 1'b1;
                    len      = $urandom_range(1, 8);
                end else if (sel < 92) begin
                    m_ready <= 1'b0;
                    len      = $urandom_range(1, 3);
                end else begin
                    m_ready <= 1'b0;
                    len      = $urandom_range(15, 50);
                end
            end
            repeat (len) @(posedge aclk);
        end
    end

    // Yield with nothing to run, and a request code with no meaning
    task automatic test_empty_yield();
        send_request(make_req(rrtp_pkg::REQ_YIELD, 0, rrtp_pkg::ST_FREE, 16'h0000));
        send_request(make_req(REQ_UNUSED, NUM_TASKS - 1, 3'd7, 16'hFFFF));
    endtask

    // Runnable tasks taking over from a free and from a running task
    task automatic test_takeover();
        send_request(make_req(rrtp_pkg::REQ_WRITE_STATE, 3, rrtp_pkg::ST_RUNNABLE, 16'h0000));
        send_request(make_req(rrtp_pkg::REQ_WRITE_STATE, NUM_TASKS - 1, rrtp_pkg::ST_RUNNABLE,
                              16'h0000));
        send_request(make_req(rrtp_pkg::REQ_WRITE_TICKS, 3, rrtp_pkg::ST_FREE, 16'hFFFF));
        send_request(make_req(rrtp_pkg::REQ_YIELD, 0, rrtp_pkg::ST_FREE, 16'h0000));
        send_request(make_req(rrtp_pkg::REQ_YIELD, 0, rrtp_pkg::ST_FREE, 16'h0000));
        send_request(make_req(rrtp_pkg::REQ_WRITE_TICKS, 0, rrtp_pkg::ST_FREE, 16'h8001));
        send_request(make_req(rrtp_pkg::REQ_YIELD, 0, rrtp_pkg::ST_FREE, 16'h0000));
    endtask

    // Codes 5..7: never picked, and a current task holding one is never replaced
    task automatic test_undefined_states();
        send_request(make_req(rrtp_pkg::REQ_WRITE_STATE, sched_cur, 3'd7, 16'h0000));
        send_request(make_req(rrtp_pkg::REQ_WRITE_STATE, 5, 3'd5, 16'h0000));
        send_request(make_req(rrtp_pkg::REQ_WRITE_STATE, 6, 3'd6, 16'h0000));
        send_request(make_req(rrtp_pkg::REQ_YIELD, 0, rrtp_pkg::ST_FREE, 16'h0000));
    endtask

    // Running entries met by the scan become current and get their ticks refilled
    task automatic test_running_scan();
        send_request(make_req(rrtp_pkg::REQ_WRITE_STATE, 9, rrtp_pkg::ST_RUNNING, 16'h0000));
        send_request(make_req(rrtp_pkg::REQ_YIELD, 0, rrtp_pkg::ST_FREE, 16'h0000));
        send_request(make_req(rrtp_pkg::REQ_WRITE_STATE, 0, rrtp_pkg::ST_RUNNING, 16'h0000));
        send_request(make_req(rrtp_pkg::REQ_WRITE_STATE, 1, rrtp_pkg::ST_RUNNING, 16'h0000));
        send_request(make_req(rrtp_pkg::REQ_YIELD, 0, rrtp_pkg::ST_FREE, 16'h0000));
    endtask

    // Sleeping, stopped and freed current task gives way to the next runnable one
    task automatic test_blocked_current();
        send_request(make_req(rrtp_pkg::REQ_WRITE_STATE, sched_cur, rrtp_pkg::ST_SLEEP,
                              16'h0000));
        send_request(make_req(rrtp_pkg::REQ_YIELD, 0, rrtp_pkg::ST_FREE, 16'h0000));
        send_request(make_req(rrtp_pkg::REQ_WRITE_STATE, sched_cur, rrtp_pkg::ST_STOP,
                              16'h0000));
        send_request(make_req(rrtp_pkg::REQ_YIELD, 0, rrtp_pkg::ST_FREE, 16'h0000));
        send_request(make_req(rrtp_pkg::REQ_WRITE_STATE, sched_cur, rrtp_pkg::ST_FREE,
                              16'h0000));
        send_request(make_req(rrtp_pkg::REQ_YIELD, 0, rrtp_pkg::ST_FREE, 16'h0000));
    endtask

    // Quantum of zero, all ones and one, each seen through a demotion reload
    task automatic test_quantum_extremes();
        wait_idle();
        set_quantum(16'h0000);
        send_request(make_req(rrtp_pkg::REQ_WRITE_STATE, 2, rrtp_pkg::ST_RUNNABLE, 16'h0000));
        send_request(make_req(rrtp_pkg::REQ_WRITE_STATE, 4, rrtp_pkg::ST_RUNNABLE, 16'h0000));
        send_request(make_req(rrtp_pkg::REQ_YIELD, 0, rrtp_pkg::ST_FREE, 16'h0000));
        send_request(make_req(rrtp_pkg::REQ_YIELD, 0, rrtp_pkg::ST_FREE, 16'h0000));
        wait_idle();
        set_quantum(16'hFFFF);
        send_request(make_req(rrtp_pkg::REQ_YIELD, 0, rrtp_pkg::ST_FREE, 16'h0000));
        send_request(make_req(rrtp_pkg::REQ_YIELD, 0, rrtp_pkg::ST_FREE, 16'h0000));
        wait_idle();
        set_quantum(16'h0001);
        send_request(make_req(rrtp_pkg::REQ_YIELD, 0, rrtp_pkg::ST_FREE, 16'h0000));
        wait_idle();
        set_quantum(rrtp_pkg::QUANTUM_RESET);
    endtask

    task automatic test_random_traffic(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_request(random_request());
    endtask

    // Long result stall while requests keep coming, so the input backs up
    task automatic test_output_backpressure();
        wait_idle();
        hold_request <= 1'b1;
        do @(posedge aclk); while (hold_request);
        tx_no_gaps = 1'b1;
        test_random_traffic(30);
        tx_no_gaps = 1'b0;
    endtask

    initial begin : main_sequence
        int i;
        int qv;
        for (i = 0; i < NUM_TASKS; i++) begin
            sched_state[i] = rrtp_pkg::ST_FREE;
            sched_ticks[i] = '0;
        end
        sched_cur     = 0;
        sched_quantum = rrtp_pkg::QUANTUM_RESET;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_yield();
        test_takeover();
        test_undefined_states();
        test_running_scan();
        test_blocked_current();
        test_quantum_extremes();

        test_random_traffic(110);
        wait_idle();
        qv = $urandom_range(1, 65535);
        set_quantum(qv[rrtp_pkg::TICKS_W-1:0]);
        test_random_traffic(100);
        test_output_backpressure();
        wait_idle();
        qv = $urandom_range(0, 15);
        set_quantum(qv[rrtp_pkg::TICKS_W-1:0]);
        tx_no_gaps = 1'b1;
        test_random_traffic(80);
        tx_no_gaps = 1'b0;
        wait_idle();
        qv = $urandom_range(1, 65535);
        set_quantum(qv[rrtp_pkg::TICKS_W-1:0]);
        test_random_traffic(100);

        // drain and watch for stray results
        wait_idle();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0 && expected_rsp.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
